>>> hw/rtl/ubq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ubq_pkg;

	localparam int RX_DEPTH = 32;
	localparam int TX_DEPTH = 64;
	localparam int RX_PTR_W = $clog2(RX_DEPTH);
	localparam int TX_PTR_W = $clog2(TX_DEPTH);

	localparam int BYTE_W   = 8;
	localparam int CLK_W    = 26;
	localparam int BAUD_W   = 20;
	localparam int THR_W    = 24;
	localparam int DIVR_W   = 16;
	localparam int DCNT_W   = $clog2(CLK_W + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_BAUD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd1;

	localparam logic [BAUD_W-1:0] BAUD_RESET   = 20'd9600;
	localparam logic [THR_W-1:0]  THRESH_RESET = 24'd8000;

	localparam logic [2:0] MODE_RX_BYTE = 3'd0;
	localparam logic [2:0] MODE_HOST_RD = 3'd1;
	localparam logic [2:0] MODE_HOST_WR = 3'd2;
	localparam logic [2:0] MODE_TX_RDY  = 3'd3;
	localparam logic [2:0] MODE_CLK_CHG = 3'd4;

	typedef struct packed {
		logic [2:0]        mode;
		logic [BYTE_W-1:0] rx_byte;
		logic              parity_error;
		logic [BYTE_W-1:0] tx_byte;
		logic [CLK_W-1:0]  clock_freq;
	} in_word_t;

	typedef struct packed {
		logic              read_valid;
		logic [BYTE_W-1:0] read_byte;
		logic              write_accepted;
		logic              send_valid;
		logic [BYTE_W-1:0] send_byte;
		logic              tx_irq_enabled;
		logic              divisor_updated;
		logic [DIVR_W-1:0] baud_divisor;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic commit;
	} ubq_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_busy;
	} ubq_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ubq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ubq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/ubq_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ubq_div
	import ubq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CLK_W-1:0]  dividend,
	input  wire logic [BAUD_W-1:0] divisor,
	output logic                   busy,
	output logic      [CLK_W-1:0]  quotient
);

	logic [BAUD_W-1:0] rem_q;
	logic [CLK_W-1:0]  quo_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic [BAUD_W:0]   rem_sh;
	logic [BAUD_W:0]   rem_nxt;
	logic              ge;

	// restoring division, one quotient bit per cycle
	always_comb begin
		rem_sh  = {rem_q, quo_q[CLK_W-1]};
		ge      = (rem_sh >= {1'b0, divisor});
		rem_nxt = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(CLK_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt[BAUD_W-1:0];
			quo_q <= {quo_q[CLK_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> hw/rtl/ubq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ubq_datapath
	import ubq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ubq_cmd_t              cmd,
	output ubq_stat_t                  st,
	input  wire in_word_t              in_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output out_word_t                  out_data
);

	in_word_t          item_q;
	out_word_t         out_q;
	out_word_t         res;
	logic [RX_PTR_W-1:0] rx_wp_q, rx_rp_q, rx_wp_n, rx_rp_n, rx_wp_inc, rx_rp_inc;
	logic [TX_PTR_W-1:0] tx_wp_q, tx_rp_q, tx_wp_n, tx_rp_n, tx_wp_inc, tx_rp_inc;
	logic              tx_en_q, tx_en_n;
	logic [CLK_W-1:0]  last_clk_q, last_clk_n;
	logic [DIVR_W-1:0] div_q, div_n, div_sat;
	logic [BAUD_W-1:0] baud_q;
	logic [THR_W-1:0]  thresh_q;
	logic [CLK_W-1:0]  diff;
	logic              need_div;
	logic              rx_we, tx_we;
	logic [BYTE_W-1:0] rx_rd, tx_rd;
	logic              div_busy;
	logic [CLK_W-1:0]  quotient;

	ubq_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we & cmd.commit),
		.waddr (rx_wp_q),
		.wdata (item_q.rx_byte),
		.raddr (rx_rp_q),
		.rdata (rx_rd)
	);

	ubq_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we & cmd.commit),
		.waddr (tx_wp_q),
		.wdata (item_q.tx_byte),
		.raddr (tx_rp_q),
		.rdata (tx_rd)
	);

	ubq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (item_q.clock_freq),
		.divisor  (baud_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		rx_wp_inc = (rx_wp_q == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_wp_q + 1'b1;
		rx_rp_inc = (rx_rp_q == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_rp_q + 1'b1;
		tx_wp_inc = (tx_wp_q == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_wp_q + 1'b1;
		tx_rp_inc = (tx_rp_q == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_rp_q + 1'b1;
		diff = (last_clk_q > item_q.clock_freq) ? (last_clk_q - item_q.clock_freq)
		                                        : (item_q.clock_freq - last_clk_q);
		need_div = (item_q.mode == MODE_CLK_CHG) && (diff > CLK_W'(thresh_q));
		// zero baud rate or an oversized quotient saturates
		div_sat = ((baud_q == '0) || (|quotient[CLK_W-1:DIVR_W])) ? '1
		                                                          : quotient[DIVR_W-1:0];
	end

	always_comb begin
		rx_wp_n    = rx_wp_q;
		rx_rp_n    = rx_rp_q;
		tx_wp_n    = tx_wp_q;
		tx_rp_n    = tx_rp_q;
		tx_en_n    = tx_en_q;
		last_clk_n = last_clk_q;
		div_n      = div_q;
		rx_we      = 1'b0;
		tx_we      = 1'b0;
		res        = '0;
		case (item_q.mode)
			MODE_RX_BYTE: begin
				if (!item_q.parity_error) begin
					rx_we   = 1'b1;
					rx_wp_n = rx_wp_inc;
				end
			end
			MODE_HOST_RD: begin
				if (rx_wp_q != rx_rp_q) begin
					res.read_valid = 1'b1;
					res.read_byte  = rx_rd;
					rx_rp_n        = rx_rp_inc;
				end
			end
			MODE_HOST_WR: begin
				if (tx_wp_inc != tx_rp_q) begin
					tx_we              = 1'b1;
					tx_wp_n            = tx_wp_inc;
					tx_en_n            = 1'b1;
					res.write_accepted = 1'b1;
				end
			end
			MODE_TX_RDY: begin
				if (tx_en_q) begin
					if (tx_wp_q != tx_rp_q) begin
						res.send_valid = 1'b1;
						res.send_byte  = tx_rd;
						tx_rp_n        = tx_rp_inc;
					end else begin
						tx_en_n = 1'b0;
					end
				end
			end
			MODE_CLK_CHG: begin
				if (need_div) begin
					last_clk_n          = item_q.clock_freq;
					div_n               = div_sat;
					res.divisor_updated = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.tx_irq_enabled = tx_en_n;
		res.baud_divisor   = div_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wp_q    <= '0;
			rx_rp_q    <= '0;
			tx_wp_q    <= '0;
			tx_rp_q    <= '0;
			tx_en_q    <= 1'b0;
			last_clk_q <= '0;
			div_q      <= '0;
			baud_q     <= BAUD_RESET;
			thresh_q   <= THRESH_RESET;
		end else begin
			if (cmd.commit) begin
				rx_wp_q    <= rx_wp_n;
				rx_rp_q    <= rx_rp_n;
				tx_wp_q    <= tx_wp_n;
				tx_rp_q    <= tx_rp_n;
				tx_en_q    <= tx_en_n;
				last_clk_q <= last_clk_n;
				div_q      <= div_n;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_BAUD:   baud_q   <= cfg_wdata[BAUD_W-1:0];
					REG_THRESH: thresh_q <= cfg_wdata[THR_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	assign st.need_div = need_div;
	assign st.div_busy = div_busy;
	assign out_data    = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/ubq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ubq_ctrl
	import ubq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire ubq_stat_t st,
	output ubq_cmd_t       cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	always_comb begin
		slot_free     = !out_valid_q || out_ready;
		in_ready      = (state_q == S_IDLE);
		cmd.load      = in_valid && in_ready;
		cmd.div_start = (state_q == S_EXEC) && st.need_div;
		cmd.commit    = slot_free &&
		                (((state_q == S_EXEC) && !st.need_div) ||
		                 ((state_q == S_DIV) && !st.div_busy));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.div_start) begin
						state_q <= S_DIV;
					end else if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a word is in flight");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed word not presented");
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> st.div_busy)
		else $error("divider did not start");
	a_no_commit_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !cmd.commit)
		else $error("commit while divider starting");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/uart_buffered_queues_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                          | dir | notes
// ----------+----------------------------------+-----+------------------------------
// input     | in_valid, in_ready, in_data      | in  | one event word per handshake
// output    | out_valid, out_ready, out_data   | out | one result word per event
// config    | cfg_we, cfg_idx, cfg_wdata       | in  | 0 baud rate, 1 change threshold
//
// an event is accepted, then the ring ram read port returns data and the result
// commits into the output register
// a clock change that recomputes the divisor runs the divider, one bit per cycle:
// accept, start, 26 divider steps, then commit
// reset clears pointers, enable flag, divisor and last clock; ring contents are
// not cleared, so no clearing pass
// a full output register stalls the commit; the next word is taken once committed

module uart_buffered_queues_top
	import ubq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_word_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	// commands from the sequencer, status back from the datapath
	ubq_cmd_t  cmd;
	ubq_stat_t st;

	// sequencer: idle, execute, wait on divider
	ubq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// rings, pointers, divisor tracking, config registers and output register
	ubq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
